/* rtl/core/psat_pkg.sv */
// Shared constants and types for the polygon separating-axis overlap core.
package psat_pkg;

   // Default vertex capacity of each polygon store.
   localparam int PSAT_MAX_VERTICES = 16;

   // Coordinate width (Q16.16) and the width of projections and distances.
   localparam int COORD_W = 32;
   localparam int PROD_W  = 64;

   // Half of one output LSB before the final 30-bit drop.
   localparam logic [PROD_W-1:0] RND_HALF = 64'd1 << 29;

   // Projection transaction that walks down the row of vertex cells.
   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      logic                      have_a;
      logic signed [PROD_W-1:0]  lo_a;
      logic signed [PROD_W-1:0]  hi_a;
      logic                      have_b;
      logic signed [PROD_W-1:0]  lo_b;
      logic signed [PROD_W-1:0]  hi_b;
   } proj_token_type;

endpackage

/* rtl/core/psat_if.sv */
// Valid/ready channel interfaces for vertex requests and overlap responses.
interface psat_req_if import psat_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic                      end_of_query;

   modport source (output valid, func, vertex_x, vertex_y, end_of_query, input ready);
   modport sink   (input valid, func, vertex_x, vertex_y, end_of_query, output ready);
endinterface

interface psat_rsp_if import psat_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      overlap;
   logic signed [COORD_W-1:0] push_x;
   logic signed [COORD_W-1:0] push_y;
   logic                      vertex_overflow;

   modport source (output valid, overlap, push_x, push_y, vertex_overflow, input ready);
   modport sink   (input valid, overlap, push_x, push_y, vertex_overflow, output ready);
endinterface

/* rtl/core/polygon_sat_overlap_core.sv */
// Top level: vertex load, edge sequencer, projection cell row and push-out scaling.
// A vertex without end_of_query is taken while idle. For each edge of both polygons a query
// runs the normal unit (normalize shifts, 32-step root, 31-step divide), the cell row and the
// sequencing states; each pass adds a start state, then the push vector is scaled and loaded
// into the response register.
// Throughput: one vertex per cycle while idle, one query in flight. Reset: synchronous, clears counts.
module polygon_sat_overlap_core import psat_pkg::*; #(
   parameter int MAX_VERTICES = PSAT_MAX_VERTICES
) (
   input logic        clock,
   input logic        reset,
   psat_req_if.sink   req_ch,
   psat_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_FETCH  = 4'd2;
   localparam logic [3:0] S_NSTART = 4'd3;
   localparam logic [3:0] S_NWAIT  = 4'd4;
   localparam logic [3:0] S_PROJ   = 4'd5;
   localparam logic [3:0] S_CHECK  = 4'd6;
   localparam logic [3:0] S_UPDATE = 4'd7;
   localparam logic [3:0] S_CHOOSE = 4'd8;
   localparam logic [3:0] S_MULT   = 4'd9;
   localparam logic [3:0] S_ROUND  = 4'd10;
   localparam logic [3:0] S_FINISH = 4'd11;

   logic [3:0]                state_ff, state_in;
   logic                      req_fire, rsp_free;
   logic [CNT_W-1:0]          cnt_a_ff, cnt_b_ff, n_own, edge_ff, edge_nxt;
   logic                      ovf_ff, full_a, full_b, wr_a, wr_b, last_edge;
   logic [IDX_W-1:0]          wr_idx, rd_idx;
   logic signed [COORD_W-1:0] rd_x, rd_y, prev_x_ff, prev_y_ff;
   logic signed [COORD_W:0]   px_ff, py_ff;
   logic                      pass_ff, first_ff;

   logic                      norm_start, norm_done;
   logic signed [COORD_W-1:0] norm_x, norm_y, cur_nx_ff, cur_ny_ff;

   proj_token_type            tok_head;
   proj_token_type            chain_tok [MAX_VERTICES+1];
   proj_token_type            tok_last;
   logic signed [COORD_W-1:0] cell_ax [MAX_VERTICES];
   logic signed [COORD_W-1:0] cell_ay [MAX_VERTICES];
   logic signed [COORD_W-1:0] cell_bx [MAX_VERTICES];
   logic signed [COORD_W-1:0] cell_by [MAX_VERTICES];
   logic signed [PROD_W-1:0]  lo_own, hi_own, lo_oth, hi_oth, d0_ff, nd1_ff;

   logic [PROD_W-1:0]         tmag_ff, best_mag_ff, p0_mag_ff, sel_mag_ff;
   logic                      tneg_ff, best_neg_ff, p0_neg_ff, sel_neg_ff, flip_ff;
   logic signed [COORD_W-1:0] best_nx_ff, best_ny_ff, p0_nx_ff, p0_ny_ff;
   logic signed [COORD_W-1:0] sel_nx_ff, sel_ny_ff, nsel;
   logic [COORD_W-2:0]        nmag;
   logic                      comp_ff, pneg_ff, sep;
   logic [PROD_W-1:0]         prod_ff, rnd;
   logic [33:0]               qv;
   logic [COORD_W-1:0]        qc, scaled;

   logic                      res_hit_ff, rsp_valid_ff, rsp_hit_ff, rsp_ovf_ff;
   logic signed [COORD_W-1:0] res_x_ff, res_y_ff, rsp_x_ff, rsp_y_ff;

   // Handshakes and vertex store writes.
   assign req_ch.ready = state_ff == S_IDLE;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign full_a       = cnt_a_ff >= CNT_W'(MAX_VERTICES);
   assign full_b       = cnt_b_ff >= CNT_W'(MAX_VERTICES);
   assign wr_a         = req_fire && !req_ch.func && !full_a;
   assign wr_b         = req_fire && req_ch.func && !full_b;
   assign wr_idx       = req_ch.func ? cnt_b_ff[IDX_W-1:0] : cnt_a_ff[IDX_W-1:0];

   // Edge walk over the polygon of the current pass.
   assign n_own     = pass_ff ? cnt_b_ff : cnt_a_ff;
   assign edge_nxt  = edge_ff + CNT_W'(1);
   assign last_edge = edge_nxt == n_own;
   assign rd_idx    = (state_ff == S_FETCH && !last_edge) ? edge_nxt[IDX_W-1:0] : '0;
   assign rd_x      = pass_ff ? cell_bx[rd_idx] : cell_ax[rd_idx];
   assign rd_y      = pass_ff ? cell_by[rd_idx] : cell_ay[rd_idx];

   psat_normal u_normal (
      .clock   (clock),
      .reset   (reset),
      .start   (norm_start),
      .edge_px (px_ff),
      .edge_py (py_ff),
      .done    (norm_done),
      .norm_x  (norm_x),
      .norm_y  (norm_y)
   );

   assign norm_start = state_ff == S_NSTART;

   // A new projection transaction enters the cell row when the normal is ready.
   always_comb begin
      tok_head        = '0;
      tok_head.valid  = state_ff == S_NWAIT && norm_done;
      tok_head.nx     = norm_x;
      tok_head.ny     = norm_y;
   end

   assign chain_tok[0] = tok_head;

   for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
      psat_cell #(
         .MAX_VERTICES (MAX_VERTICES),
         .CELL_INDEX   (gi)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_a    (wr_a),
         .wr_b    (wr_b),
         .wr_idx  (wr_idx),
         .wr_x    (req_ch.vertex_x),
         .wr_y    (req_ch.vertex_y),
         .cnt_a   (cnt_a_ff),
         .cnt_b   (cnt_b_ff),
         .tok_in  (chain_tok[gi]),
         .tok_out (chain_tok[gi+1]),
         .vx_a    (cell_ax[gi]),
         .vy_a    (cell_ay[gi]),
         .vx_b    (cell_bx[gi]),
         .vy_b    (cell_by[gi])
      );
   end

   // Intervals of the polygon that owns the axis and of the other one.
   assign tok_last = chain_tok[MAX_VERTICES];
   assign lo_own   = pass_ff ? tok_last.lo_b : tok_last.lo_a;
   assign hi_own   = pass_ff ? tok_last.hi_b : tok_last.hi_a;
   assign lo_oth   = pass_ff ? tok_last.lo_a : tok_last.lo_b;
   assign hi_oth   = pass_ff ? tok_last.hi_a : tok_last.hi_b;
   assign sep      = d0_ff <= 64'sd0 || nd1_ff <= 64'sd0;

   // Output scaling: magnitude product, half-up rounding and saturation.
   assign nsel   = comp_ff ? sel_ny_ff : sel_nx_ff;
   assign nmag   = 31'(nsel < 0 ? -nsel : nsel);
   assign rnd    = prod_ff + RND_HALF;
   assign qv     = rnd[63:30];
   assign qc     = (qv > 34'h080000000) ? 32'h80000000 : qv[31:0];
   assign scaled = pneg_ff ? -qc : ((qv > 34'h07FFFFFFF) ? 32'h7FFFFFFF : qv[31:0]);

   // Query sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_ch.end_of_query) begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = (cnt_a_ff == '0 || cnt_b_ff == '0) ? S_FINISH : S_FETCH;
         end
         S_FETCH:  state_in = S_NSTART;
         S_NSTART: state_in = S_NWAIT;
         S_NWAIT: begin
            if (norm_done) begin
               state_in = S_PROJ;
            end
         end
         S_PROJ: begin
            if (tok_last.valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = sep ? S_FINISH : S_UPDATE;
         S_UPDATE: begin
            if (!last_edge) begin
               state_in = S_FETCH;
            end else if (!pass_ff) begin
               state_in = S_START;
            end else begin
               state_in = S_CHOOSE;
            end
         end
         S_CHOOSE: state_in = S_MULT;
         S_MULT:   state_in = S_ROUND;
         S_ROUND:  state_in = comp_ff ? S_FINISH : S_MULT;
         S_FINISH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FINISH && rsp_free) begin
            cnt_a_ff <= '0;
            cnt_b_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            if (wr_a) begin
               cnt_a_ff <= cnt_a_ff + CNT_W'(1);
            end
            if (wr_b) begin
               cnt_b_ff <= cnt_b_ff + CNT_W'(1);
            end
            if (req_fire && (req_ch.func ? full_b : full_a)) begin
               ovf_ff <= 1'b1;
            end
         end
         if (state_ff == S_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers of the edge walk and result selection.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            pass_ff    <= 1'b0;
            res_hit_ff <= 1'b0;
            res_x_ff   <= '0;
            res_y_ff   <= '0;
         end
         S_START: begin
            prev_x_ff <= rd_x;
            prev_y_ff <= rd_y;
            edge_ff   <= '0;
            first_ff  <= 1'b1;
         end
         S_FETCH: begin
            px_ff     <= 33'(prev_y_ff) - 33'(rd_y);
            py_ff     <= 33'(rd_x) - 33'(prev_x_ff);
            prev_x_ff <= rd_x;
            prev_y_ff <= rd_y;
         end
         S_NWAIT: begin
            cur_nx_ff <= norm_x;
            cur_ny_ff <= norm_y;
         end
         S_PROJ: begin
            d0_ff  <= hi_oth - lo_own;
            nd1_ff <= hi_own - lo_oth;
         end
         S_CHECK: begin
            if (d0_ff < nd1_ff) begin
               tmag_ff <= d0_ff;
               tneg_ff <= 1'b0;
            end else begin
               tmag_ff <= nd1_ff;
               tneg_ff <= 1'b1;
            end
         end
         S_UPDATE: begin
            // Equal magnitudes keep the earlier axis.
            if (first_ff || tmag_ff < best_mag_ff) begin
               best_mag_ff <= tmag_ff;
               best_neg_ff <= tneg_ff;
               best_nx_ff  <= cur_nx_ff;
               best_ny_ff  <= cur_ny_ff;
               first_ff    <= 1'b0;
            end
            if (!last_edge) begin
               edge_ff <= edge_nxt;
            end else if (!pass_ff) begin
               pass_ff <= 1'b1;
               if (first_ff || tmag_ff < best_mag_ff) begin
                  p0_mag_ff <= tmag_ff;
                  p0_neg_ff <= tneg_ff;
                  p0_nx_ff  <= cur_nx_ff;
                  p0_ny_ff  <= cur_ny_ff;
               end else begin
                  p0_mag_ff <= best_mag_ff;
                  p0_neg_ff <= best_neg_ff;
                  p0_nx_ff  <= best_nx_ff;
                  p0_ny_ff  <= best_ny_ff;
               end
            end
         end
         S_CHOOSE: begin
            // A tie between the passes takes the second polygon's vector.
            res_hit_ff <= 1'b1;
            comp_ff    <= 1'b0;
            if (p0_mag_ff < best_mag_ff) begin
               sel_mag_ff <= p0_mag_ff;
               sel_neg_ff <= p0_neg_ff;
               sel_nx_ff  <= p0_nx_ff;
               sel_ny_ff  <= p0_ny_ff;
               flip_ff    <= 1'b0;
            end else begin
               sel_mag_ff <= best_mag_ff;
               sel_neg_ff <= best_neg_ff;
               sel_nx_ff  <= best_nx_ff;
               sel_ny_ff  <= best_ny_ff;
               flip_ff    <= 1'b1;
            end
         end
         S_MULT: begin
            prod_ff <= 64'(nmag * sel_mag_ff[63:30]);
            pneg_ff <= ((nsel < 0) != sel_neg_ff) != flip_ff;
         end
         S_ROUND: begin
            if (comp_ff) begin
               res_y_ff <= scaled;
            end else begin
               res_x_ff <= scaled;
            end
            comp_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Response register, loaded when the query completes.
   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && rsp_free) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_x_ff   <= res_x_ff;
         rsp_y_ff   <= res_y_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.overlap         = rsp_hit_ff;
   assign rsp_ch.push_x          = rsp_x_ff;
   assign rsp_ch.push_y          = rsp_y_ff;
   assign rsp_ch.vertex_overflow = rsp_ovf_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_a_ff <= CNT_W'(MAX_VERTICES) && cnt_b_ff <= CNT_W'(MAX_VERTICES))
      else $error("Vertex count exceeds the store capacity.");

   a_zero_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0)
      else $error("Nonzero push vector reported without overlap.");

   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && rsp_free |=> cnt_a_ff == '0 && cnt_b_ff == '0 && !ovf_ff)
      else $error("Vertex stores not emptied after a query result.");

   a_chain_timing: assert property (@(posedge clock) disable iff (reset)
      tok_last.valid |-> state_ff == S_PROJ)
      else $error("Projection transaction left the cell row outside the wait state.");

endmodule

/* rtl/core/psat_cell.sv */
// One vertex cell: holds a vertex of each polygon and folds it into the projection chain.
module psat_cell import psat_pkg::*; #(
   parameter int MAX_VERTICES = PSAT_MAX_VERTICES,
   parameter int CELL_INDEX   = 0,
   localparam int IDX_W = $clog2(MAX_VERTICES),
   localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_a,
   input  logic                      wr_b,
   input  logic [IDX_W-1:0]          wr_idx,
   input  logic signed [COORD_W-1:0] wr_x,
   input  logic signed [COORD_W-1:0] wr_y,
   input  logic [CNT_W-1:0]          cnt_a,
   input  logic [CNT_W-1:0]          cnt_b,
   input  proj_token_type            tok_in,
   output proj_token_type            tok_out,
   output logic signed [COORD_W-1:0] vx_a,
   output logic signed [COORD_W-1:0] vy_a,
   output logic signed [COORD_W-1:0] vx_b,
   output logic signed [COORD_W-1:0] vy_b
);

   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   proj_token_type            s1_ff, out_ff, out_in;
   logic                      s1_valid_ff, out_valid_ff;
   logic signed [PROD_W-1:0]  pax_ff, pay_ff, pbx_ff, pby_ff;
   logic signed [PROD_W-1:0]  dot_a, dot_b;
   logic                      act_a, act_b;

   // Vertex storage, written when the load index selects this cell.
   always_ff @(posedge clock) begin
      if (wr_a && wr_idx == IDX_W'(CELL_INDEX)) begin
         ax_ff <= wr_x;
         ay_ff <= wr_y;
      end
      if (wr_b && wr_idx == IDX_W'(CELL_INDEX)) begin
         bx_ff <= wr_x;
         by_ff <= wr_y;
      end
   end

   assign vx_a = ax_ff;
   assign vy_a = ay_ff;
   assign vx_b = bx_ff;
   assign vy_b = by_ff;

   // First stage: the four partial products of both dot products.
   always_ff @(posedge clock) begin
      s1_ff  <= tok_in;
      pax_ff <= tok_in.nx * ax_ff;
      pay_ff <= tok_in.ny * ay_ff;
      pbx_ff <= tok_in.nx * bx_ff;
      pby_ff <= tok_in.ny * by_ff;
   end

   // Second stage: sum and widen the intervals when this cell holds a live vertex.
   assign dot_a = pax_ff + pay_ff;
   assign dot_b = pbx_ff + pby_ff;
   assign act_a = cnt_a > CNT_W'(CELL_INDEX);
   assign act_b = cnt_b > CNT_W'(CELL_INDEX);

   always_comb begin
      out_in = s1_ff;
      if (act_a) begin
         if (!s1_ff.have_a) begin
            out_in.have_a = 1'b1;
            out_in.lo_a   = dot_a;
            out_in.hi_a   = dot_a;
         end else if (dot_a < s1_ff.lo_a) begin
            out_in.lo_a = dot_a;
         end else if (dot_a > s1_ff.hi_a) begin
            out_in.hi_a = dot_a;
         end
      end
      if (act_b) begin
         if (!s1_ff.have_b) begin
            out_in.have_b = 1'b1;
            out_in.lo_b   = dot_b;
            out_in.hi_b   = dot_b;
         end else if (dot_b < s1_ff.lo_b) begin
            out_in.lo_b = dot_b;
         end else if (dot_b > s1_ff.hi_b) begin
            out_in.hi_b = dot_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // Only the valid flags of the chain need a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= tok_in.valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_comb begin
      tok_out       = out_ff;
      tok_out.valid = out_valid_ff;
   end

endmodule

/* rtl/core/psat_normal.sv */
// Iterative unit edge-normal generator: normalize, bitwise square root, restoring divide.
module psat_normal import psat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W:0]   edge_px,
   input  logic signed [COORD_W:0]   edge_py,
   output logic                      done,
   output logic signed [COORD_W-1:0] norm_x,
   output logic signed [COORD_W-1:0] norm_y
);

   localparam logic [2:0] N_IDLE   = 3'd0;
   localparam logic [2:0] N_SHIFT  = 3'd1;
   localparam logic [2:0] N_SQUARE = 3'd2;
   localparam logic [2:0] N_SUM    = 3'd3;
   localparam logic [2:0] N_ROOT   = 3'd4;
   localparam logic [2:0] N_DINIT  = 3'd5;
   localparam logic [2:0] N_DIV    = 3'd6;
   localparam logic [2:0] N_DONE   = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [COORD_W:0]          mx_ff, my_ff, big;
   logic                      neg_x_ff, neg_y_ff;
   logic [61:0]               sq_x_ff, sq_y_ff;
   logic [63:0]               rad_ff, root_ff, bit_ff, trial;
   logic [4:0]                step_ff;
   logic [31:0]               rem_x_ff, rem_y_ff, len;
   logic [30:0]               low_x_ff, low_y_ff, quo_x_ff, quo_y_ff;
   logic [32:0]               part_x, part_y;
   logic                      ge_x, ge_y;
   logic                      done_ff;
   logic signed [COORD_W-1:0] norm_x_ff, norm_y_ff, qx_s, qy_s;

   assign big   = (mx_ff > my_ff) ? mx_ff : my_ff;
   assign trial = root_ff + bit_ff;
   assign len   = root_ff[31:0];

   // One restoring divide step for each component.
   assign part_x = {rem_x_ff, low_x_ff[30]};
   assign part_y = {rem_y_ff, low_y_ff[30]};
   assign ge_x   = part_x >= {1'b0, len};
   assign ge_y   = part_y >= {1'b0, len};

   assign qx_s = {1'b0, quo_x_ff};
   assign qy_s = {1'b0, quo_y_ff};

   // Sequencer of the normal computation.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               state_in = (edge_px == '0 && edge_py == '0) ? N_DONE : N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (big[32:31] == 2'b00 && big[30]) begin
               state_in = N_SQUARE;
            end
         end
         N_SQUARE: state_in = N_SUM;
         N_SUM:    state_in = N_ROOT;
         N_ROOT: begin
            if (step_ff == 5'd31) begin
               state_in = N_DINIT;
            end
         end
         N_DINIT: state_in = N_DIV;
         N_DIV: begin
            if (step_ff == 5'd30) begin
               state_in = N_DONE;
            end
         end
         N_DONE:  state_in = N_IDLE;
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= state_ff == N_DONE;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         N_IDLE: begin
            mx_ff    <= edge_px[COORD_W] ? 33'(-edge_px) : 33'(edge_px);
            my_ff    <= edge_py[COORD_W] ? 33'(-edge_py) : 33'(edge_py);
            neg_x_ff <= edge_px[COORD_W];
            neg_y_ff <= edge_py[COORD_W];
            quo_x_ff <= '0;
            quo_y_ff <= '0;
         end
         N_SHIFT: begin
            // Bits shifted out on the right are lost.
            if (big[32:31] != 2'b00) begin
               mx_ff <= mx_ff >> 1;
               my_ff <= my_ff >> 1;
            end else if (!big[30]) begin
               mx_ff <= mx_ff << 1;
               my_ff <= my_ff << 1;
            end
         end
         N_SQUARE: begin
            sq_x_ff <= mx_ff[30:0] * mx_ff[30:0];
            sq_y_ff <= my_ff[30:0] * my_ff[30:0];
         end
         N_SUM: begin
            rad_ff  <= {2'b00, sq_x_ff} + {2'b00, sq_y_ff};
            root_ff <= '0;
            bit_ff  <= 64'd1 << 62;
            step_ff <= '0;
         end
         N_ROOT: begin
            if (rad_ff >= trial) begin
               rad_ff  <= rad_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + 5'd1;
         end
         N_DINIT: begin
            // The quotient fits in 31 bits, so the upper dividend bits start the remainder.
            rem_x_ff <= {2'b00, mx_ff[30:1]};
            rem_y_ff <= {2'b00, my_ff[30:1]};
            low_x_ff <= {mx_ff[0], 30'd0};
            low_y_ff <= {my_ff[0], 30'd0};
            step_ff  <= '0;
         end
         N_DIV: begin
            rem_x_ff <= ge_x ? 32'(part_x - {1'b0, len}) : part_x[31:0];
            rem_y_ff <= ge_y ? 32'(part_y - {1'b0, len}) : part_y[31:0];
            low_x_ff <= low_x_ff << 1;
            low_y_ff <= low_y_ff << 1;
            quo_x_ff <= {quo_x_ff[29:0], ge_x};
            quo_y_ff <= {quo_y_ff[29:0], ge_y};
            step_ff  <= step_ff + 5'd1;
         end
         N_DONE: begin
            norm_x_ff <= neg_x_ff ? -qx_s : qx_s;
            norm_y_ff <= neg_y_ff ? -qy_s : qy_s;
         end
         default: begin
         end
      endcase
   end

   assign done   = done_ff;
   assign norm_x = norm_x_ff;
   assign norm_y = norm_y_ff;

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> norm_x_ff <= 32'sd1073741824 && norm_x_ff >= -32'sd1073741824 &&
                  norm_y_ff <= 32'sd1073741824 && norm_y_ff >= -32'sd1073741824)
      else $error("Unit normal component exceeds one in Q2.30.");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == N_DINIT |-> root_ff[63:32] == '0 && root_ff[31:30] != 2'b00)
      else $error("Edge length out of the normalized range before division.");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == N_IDLE)
      else $error("Normal unit started while busy.");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("Normal unit done held for more than one cycle.");

endmodule
